// ===== rtl/d8fa_pkg.sv =====
// Shared types, constants and the control store for the D8 flow accumulation step.
// Holds the cell word layout, the register and op codes, the direction tables and
// the microcode program. No dependencies.
`timescale 1ns / 1ps

package d8fa_pkg;

  // Field widths
  localparam int unsigned AccW  = 32;
  localparam int unsigned AspW  = 5;
  localparam int unsigned RowW  = 8;
  localparam int unsigned ColW  = 8;
  localparam int unsigned ThrW  = 31;
  localparam int unsigned DimW  = 9;
  localparam int unsigned OpW   = 2;
  localparam int unsigned CellW = AccW + AspW + 1;  // {swale, aspect, acc}
  localparam int unsigned InDataW  = 56;
  localparam int unsigned OutDataW = 88;

  localparam logic [ThrW-1:0] ThrDefault = ThrW'(60);
  localparam logic [ThrW-1:0] MagMax     = '1;

  // Item op codes
  typedef logic [OpW-1:0] op_t;
  localparam op_t OpLoad = 2'd0;
  localparam op_t OpAcc  = 2'd1;
  localparam op_t OpRead = 2'd2;

  // Configuration register indexes
  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgThreshold = 2'd0;
  localparam cfg_idx_t CfgPitFlag   = 2'd1;
  localparam cfg_idx_t CfgRows      = 2'd2;
  localparam cfg_idx_t CfgCols      = 2'd3;

  // Microprogram steps
  typedef enum logic [3:0] {
    S_IDLE = 4'd0,
    S_DISP = 4'd1,
    S_LOAD = 4'd2,
    S_RRD  = 4'd3,
    S_RCAP = 4'd4,
    S_ARD  = 4'd5,
    S_ACAP = 4'd6,
    S_DRD  = 4'd7,
    S_DCAP = 4'd8,
    S_SUM  = 4'd9,
    S_NEG  = 4'd10,
    S_DWR  = 4'd11,
    S_SWR  = 4'd12,
    S_ZERO = 4'd13,
    S_EMIT = 4'd14
  } step_e;

  // RAM write data source
  typedef enum logic [1:0] {
    W_LOAD,
    W_DOWN,
    W_SRC
  } wsel_e;

  // Datapath action
  typedef enum logic [2:0] {
    A_NONE,
    A_LOADCELL,
    A_CAPSRC,
    A_CAPDN,
    A_SUM,
    A_NEG,
    A_ZERO,
    A_EMIT
  } act_e;

  // Sequencing: unconditional, wait for input, op dispatch, move test, wait for output
  typedef enum logic [2:0] {
    J_GO,
    J_ACCEPT,
    J_DISPATCH,
    J_MOVE,
    J_OUT
  } jmp_e;

  typedef struct packed {
    logic  rd;
    logic  wr;
    logic  addr_dn;
    wsel_e wsel;
    act_e  act;
    jmp_e  jmp;
    step_e target;
  } ucode_t;

  function automatic ucode_t mk(input logic rd, input logic wr, input logic dn,
                                input wsel_e ws, input act_e act, input jmp_e jmp,
                                input step_e tgt);
    ucode_t w;
    w.rd      = rd;
    w.wr      = wr;
    w.addr_dn = dn;
    w.wsel    = ws;
    w.act     = act;
    w.jmp     = jmp;
    w.target  = tgt;
    return w;
  endfunction

  // Control store
  function automatic ucode_t ucode_rom(input step_e pc);
    ucode_t w;
    unique case (pc)
      S_IDLE:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_NONE,     J_ACCEPT,   S_DISP);
      S_DISP:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_NONE,     J_DISPATCH, S_ZERO);
      S_LOAD:  w = mk(1'b0, 1'b1, 1'b0, W_LOAD, A_LOADCELL, J_GO,       S_EMIT);
      S_RRD:   w = mk(1'b1, 1'b0, 1'b0, W_LOAD, A_NONE,     J_GO,       S_RCAP);
      S_RCAP:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_CAPSRC,   J_GO,       S_EMIT);
      S_ARD:   w = mk(1'b1, 1'b0, 1'b0, W_LOAD, A_NONE,     J_GO,       S_ACAP);
      S_ACAP:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_CAPSRC,   J_MOVE,     S_EMIT);
      S_DRD:   w = mk(1'b1, 1'b0, 1'b1, W_LOAD, A_NONE,     J_GO,       S_DCAP);
      S_DCAP:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_CAPDN,    J_GO,       S_SUM);
      S_SUM:   w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_SUM,      J_GO,       S_NEG);
      S_NEG:   w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_NEG,      J_GO,       S_DWR);
      S_DWR:   w = mk(1'b0, 1'b1, 1'b1, W_DOWN, A_NONE,     J_GO,       S_SWR);
      S_SWR:   w = mk(1'b0, 1'b1, 1'b0, W_SRC,  A_NONE,     J_GO,       S_EMIT);
      S_ZERO:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_ZERO,     J_GO,       S_EMIT);
      S_EMIT:  w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_EMIT,     J_OUT,      S_IDLE);
      default: w = mk(1'b0, 1'b0, 1'b0, W_LOAD, A_NONE,     J_GO,       S_IDLE);
    endcase
    return w;
  endfunction

  // Row offset for direction 1..8 (counterclockwise from northeast)
  function automatic logic signed [1:0] step_dr(input logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd1, 4'd2, 4'd3: d = -2'sd1;
      4'd5, 4'd6, 4'd7: d = 2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // Column offset for direction 1..8
  function automatic logic signed [1:0] step_dc(input logic [3:0] k);
    logic signed [1:0] d;
    case (k)
      4'd1, 4'd7, 4'd8: d = 2'sd1;
      4'd3, 4'd4, 4'd5: d = -2'sd1;
      default:          d = 2'sd0;
    endcase
    return d;
  endfunction

  // Magnitude of a 32-bit two's complement value; -2^31 gives 2^31
  function automatic logic [AccW-1:0] mag32(input logic signed [AccW-1:0] a);
    return a[AccW-1] ? AccW'(0) - AccW'(a) : AccW'(a);
  endfunction

endpackage

// ===== rtl/d8fa_ram.sv =====
// Generic single-port RAM: one write or read per cycle, registered read data.
// No dependencies.
`timescale 1ns / 1ps

module d8fa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Storage and read register
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/d8_flow_accumulation_step.sv =====
// D8 flow accumulation step: microcoded sequencer over one single-port grid RAM.
// Each item runs its own microcode path to the output register: load, read,
// accumulate with or without a downstream cell, and outside the region.
// One item at a time; the next is taken the cycle after its result is registered.
// Every grid read and write goes through the one RAM port, which limits the item rate.
// Reset sets control and config registers to their defaults only; grid cells are undefined until loaded.
`timescale 1ns / 1ps

module d8_flow_accumulation_step #(
  parameter int unsigned MAX_ROWS = 256,
  parameter int unsigned MAX_COLS = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Input stream
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: row[7:0], col[15:8], acc_in[47:16], aspect_in[52:48], swale_in[53], zero pad
  input  logic [d8fa_pkg::InDataW-1:0]         s_axis_tdata,
  // tuser: op[1:0]
  input  logic [d8fa_pkg::OpW-1:0]             s_axis_tuser,
  // Output stream
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // tdata: cell_acc[31:0], cell_aspect[36:32], cell_swale[37], down_row[45:38],
  //        down_col[53:46], down_acc[85:54], down_swale[86], zero pad
  output logic [d8fa_pkg::OutDataW-1:0]        m_axis_tdata,
  // tuser: moved[0]
  output logic [0:0]                           m_axis_tuser,
  // Configuration writes
  input  logic                                 cfg_we_i,
  input  d8fa_pkg::cfg_idx_t                   cfg_idx_i,
  input  logic [d8fa_pkg::ThrW-1:0]            cfg_data_i
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned AccW  = d8fa_pkg::AccW;
  localparam int unsigned AspW  = d8fa_pkg::AspW;
  localparam int unsigned CellW = d8fa_pkg::CellW;
  localparam int unsigned DimW  = d8fa_pkg::DimW;
  localparam int unsigned ThrW  = d8fa_pkg::ThrW;

  // Configuration
  logic [ThrW-1:0] threshold_q;
  logic            pit_q;
  logic [DimW-1:0] rows_q;
  logic [DimW-1:0] cols_q;

  // Sequencer
  d8fa_pkg::step_e  pc_q, pc_d;
  d8fa_pkg::ucode_t uc;

  // Input item
  d8fa_pkg::op_t            in_op_q;
  logic [7:0]               in_row_q;
  logic [7:0]               in_col_q;
  logic signed [AccW-1:0]   in_acc_q;
  logic signed [AspW-1:0]   in_asp_q;
  logic                     in_sw_q;

  // Source and downstream cell
  logic signed [AccW-1:0]   src_acc_q;
  logic signed [AspW-1:0]   src_asp_q;
  logic                     src_sw_q;
  logic [AccW-1:0]          src_mag_q;
  logic signed [AccW-1:0]   dn_acc_q;
  logic signed [AspW-1:0]   dn_asp_q;
  logic                     dn_sw_q;
  logic [AccW-1:0]          dn_mag_q;
  logic [7:0]               dn_row_q;
  logic [7:0]               dn_col_q;
  logic                     moved_q;
  logic [ThrW-1:0]          sum_q;
  logic                     both_pos_q;

  // Output register
  logic                     m_valid_q;
  logic [d8fa_pkg::OutDataW-1:0] m_data_q;
  logic                     m_user_q;

  // RAM
  logic [AddrW-1:0] ram_addr;
  logic [CellW-1:0] ram_wdata;
  logic [CellW-1:0] ram_rdata;

  logic                   in_hs;
  logic                   out_free;
  logic [DimW-1:0]        rows_eff;
  logic [DimW-1:0]        cols_eff;
  logic [ThrW-1:0]        thr_eff;
  logic                   in_region;
  logic signed [AccW-1:0] rd_acc;
  logic signed [AspW-1:0] rd_asp;
  logic                   rd_sw;
  logic [AspW-1:0]        asp_mag;
  logic                   dir_ok;
  logic signed [1:0]      step_r;
  logic signed [1:0]      step_c;
  logic signed [9:0]      dr;
  logic signed [9:0]      dc;
  logic                   move;
  logic [ThrW:0]          sum_raw;
  logic [ThrW-1:0]        sum_sat;
  logic                   src_sw_n;
  logic [AddrW-1:0]       src_addr;
  logic [AddrW-1:0]       dn_addr;

  assign uc            = d8fa_pkg::ucode_rom(pc_q);
  assign s_axis_tready = (pc_q == d8fa_pkg::S_IDLE);
  assign in_hs         = s_axis_tvalid & s_axis_tready;
  assign out_free      = ~m_valid_q | m_axis_tready;

  // Region and threshold as they act
  assign rows_eff  = (32'(rows_q) > MAX_ROWS) ? DimW'(MAX_ROWS) : rows_q;
  assign cols_eff  = (32'(cols_q) > MAX_COLS) ? DimW'(MAX_COLS) : cols_q;
  assign thr_eff   = (threshold_q == '0) ? d8fa_pkg::ThrDefault : threshold_q;
  assign in_region = ({1'b0, in_row_q} < rows_eff) && ({1'b0, in_col_q} < cols_eff);

  // Cell addresses (row-major, MAX_COLS per row)
  assign src_addr = AddrW'(32'(in_row_q) * MAX_COLS + 32'(in_col_q));
  assign dn_addr  = AddrW'(32'(dn_row_q) * MAX_COLS + 32'(dn_col_q));

  // Read data split and direction decode
  assign rd_acc  = ram_rdata[AccW-1:0];
  assign rd_asp  = ram_rdata[AccW +: AspW];
  assign rd_sw   = ram_rdata[CellW-1];
  assign asp_mag = rd_asp[AspW-1] ? AspW'(0) - AspW'(rd_asp) : AspW'(rd_asp);
  assign dir_ok  = (rd_asp != '0) && (asp_mag <= AspW'(8));
  assign step_r  = d8fa_pkg::step_dr(asp_mag[3:0]);
  assign step_c  = d8fa_pkg::step_dc(asp_mag[3:0]);
  assign dr = $signed({2'b00, in_row_q}) + {{8{step_r[1]}}, step_r};
  assign dc = $signed({2'b00, in_col_q}) + {{8{step_c[1]}}, step_c};
  assign move = dir_ok && !dr[9] && !dc[9] &&
                (dr < $signed({1'b0, rows_eff})) && (dc < $signed({1'b0, cols_eff}));

  // Saturating magnitude sum and stream test
  assign sum_raw  = {1'b0, src_mag_q[ThrW-1:0]} + {1'b0, dn_mag_q[ThrW-1:0]}
                    + {src_mag_q[ThrW], {ThrW{1'b0}}} + {dn_mag_q[ThrW], {ThrW{1'b0}}};
  assign sum_sat  = (src_mag_q[ThrW] | dn_mag_q[ThrW] | sum_raw[ThrW]) ?
                    d8fa_pkg::MagMax : sum_raw[ThrW-1:0];
  assign src_sw_n = src_sw_q | (src_mag_q >= {1'b0, thr_eff});

  // RAM port
  assign ram_addr = uc.addr_dn ? dn_addr : src_addr;
  always_comb begin
    case (uc.wsel)
      d8fa_pkg::W_DOWN: ram_wdata = {dn_sw_q, dn_asp_q, dn_acc_q};
      d8fa_pkg::W_SRC:  ram_wdata = {src_sw_q, src_asp_q, src_acc_q};
      default:          ram_wdata = {in_sw_q, in_asp_q, in_acc_q};
    endcase
  end

  d8fa_ram #(
    .Width (CellW),
    .Depth (Depth)
  ) u_grid (
    .clk_i   (clk_i),
    .we_i    (uc.wr),
    .re_i    (uc.rd),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Next step
  always_comb begin
    pc_d = pc_q;
    unique case (uc.jmp)
      d8fa_pkg::J_ACCEPT: begin
        if (in_hs) pc_d = uc.target;
      end
      d8fa_pkg::J_DISPATCH: begin
        if (!in_region)               pc_d = uc.target;
        else if (in_op_q == d8fa_pkg::OpLoad) pc_d = d8fa_pkg::S_LOAD;
        else if (in_op_q == d8fa_pkg::OpAcc)  pc_d = d8fa_pkg::S_ARD;
        else                          pc_d = d8fa_pkg::S_RRD;
      end
      d8fa_pkg::J_MOVE: begin
        pc_d = move ? d8fa_pkg::step_e'(4'(pc_q) + 4'd1) : uc.target;
      end
      d8fa_pkg::J_OUT: begin
        if (out_free) pc_d = uc.target;
      end
      default: pc_d = uc.target;
    endcase
  end

  // Control state, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= d8fa_pkg::S_IDLE;
      m_valid_q   <= 1'b0;
      threshold_q <= d8fa_pkg::ThrDefault;
      pit_q       <= 1'b0;
      rows_q      <= DimW'(256);
      cols_q      <= DimW'(256);
    end else begin
      pc_q <= pc_d;
      if (uc.act == d8fa_pkg::A_EMIT && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          d8fa_pkg::CfgThreshold: threshold_q <= cfg_data_i;
          d8fa_pkg::CfgPitFlag:   pit_q       <= cfg_data_i[0];
          d8fa_pkg::CfgRows:      rows_q      <= cfg_data_i[DimW-1:0];
          d8fa_pkg::CfgCols:      cols_q      <= cfg_data_i[DimW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Datapath registers, driven by the current control word
  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      in_op_q  <= s_axis_tuser;
      in_row_q <= s_axis_tdata[7:0];
      in_col_q <= s_axis_tdata[15:8];
      in_acc_q <= s_axis_tdata[47:16];
      in_asp_q <= s_axis_tdata[52:48];
      in_sw_q  <= s_axis_tdata[53];
      moved_q  <= 1'b0;
      dn_row_q <= '0;
      dn_col_q <= '0;
      dn_acc_q <= '0;
      dn_sw_q  <= 1'b0;
    end
    case (uc.act)
      d8fa_pkg::A_LOADCELL: begin
        src_acc_q <= in_acc_q;
        src_asp_q <= in_asp_q;
        src_sw_q  <= in_sw_q;
      end
      d8fa_pkg::A_CAPSRC: begin
        src_acc_q <= rd_acc;
        src_asp_q <= rd_asp;
        src_sw_q  <= rd_sw;
        src_mag_q <= d8fa_pkg::mag32(rd_acc);
        if (uc.jmp == d8fa_pkg::J_MOVE && move) begin
          moved_q  <= 1'b1;
          dn_row_q <= dr[7:0];
          dn_col_q <= dc[7:0];
        end
      end
      d8fa_pkg::A_CAPDN: begin
        dn_acc_q <= rd_acc;
        dn_asp_q <= rd_asp;
        dn_sw_q  <= rd_sw;
        dn_mag_q <= d8fa_pkg::mag32(rd_acc);
      end
      d8fa_pkg::A_SUM: begin
        sum_q      <= sum_sat;
        both_pos_q <= (src_acc_q > 0) && (dn_acc_q > 0);
        src_sw_q   <= src_sw_n;
        dn_sw_q    <= dn_sw_q | src_sw_n | (sum_sat >= thr_eff);
        // Pit rule: stream flowing into a cell without direction
        if (src_sw_n && pit_q && (src_asp_q > 0) && (dn_asp_q == '0)) begin
          src_asp_q <= AspW'(0) - src_asp_q;
        end
      end
      d8fa_pkg::A_NEG: begin
        // Sticky negative: sign stays negative unless both values are positive
        dn_acc_q <= both_pos_q ? {1'b0, sum_q} : AccW'(0) - {1'b0, sum_q};
      end
      d8fa_pkg::A_ZERO: begin
        src_acc_q <= '0;
        src_asp_q <= '0;
        src_sw_q  <= 1'b0;
      end
      d8fa_pkg::A_EMIT: begin
        if (out_free) begin
          m_data_q <= {1'b0, dn_sw_q, dn_acc_q, dn_col_q, dn_row_q,
                       src_sw_q, src_asp_q, src_acc_q};
          m_user_q <= moved_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid   = m_valid_q;
  assign m_axis_tdata    = m_data_q;
  assign m_axis_tuser[0] = m_user_q;

endmodule
